// ===== src/prpp_pkg.sv =====
// Shared types, widths, register codes and helpers of the pixel ray point projection block.
package prpp_pkg;

   // Saturation width of the coordinate results (24 .. 48); ports stay 32 bits wide.
   localparam int COORD_WIDTH = 32;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam int DIR_W     = 33;   // ray direction, Q16.16
   localparam int WDIFF_W   = 33;   // joint minus camera position
   localparam int NUM_W     = 66;   // dot product d.(J-t) / 4
   localparam int DEN_W     = 64;   // dot product d.d / 4
   localparam int MAG_W     = 64;   // magnitude of num
   localparam int PROD_W    = 97;   // |d| * |num|
   localparam int QUO_W     = 51;   // quotient bits below the clamp limit
   localparam int LIM_W     = DEN_W + QUO_W;
   localparam int SUM_W     = 53;   // width used for the final additions
   localparam int DIV_STEPS = QUO_W;

   localparam int FRONT_DEPTH = 7;
   localparam int BACK_DEPTH  = 3 + 1 + DIV_STEPS + 1 + 1;
   localparam int SIDE_DEPTH  = BACK_DEPTH - 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [QUO_W-1:0] QUO_CLAMP = QUO_W'(1) << 50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROT_ROW0  = 3'd0,
      CSR_ROT_ROW1  = 3'd1,
      CSR_ROT_ROW2  = 3'd2,
      CSR_TRANS_X   = 3'd3,
      CSR_TRANS_Y   = 3'd4,
      CSR_TRANS_Z   = 3'd5,
      CSR_INV_FOCAL = 3'd6,
      CSR_PRINCIPAL = 3'd7
   } csr_index_type;

   localparam logic [47:0] ROT_ROW0_RESET  = 48'd16384;
   localparam logic [47:0] ROT_ROW1_RESET  = 48'd1073741824;
   localparam logic [47:0] ROT_ROW2_RESET  = 48'd70368744177664;
   localparam logic [31:0] INV_FOCAL_RESET = 32'd2684355;
   localparam logic [15:0] CX_RESET        = 16'd12644;
   localparam logic [15:0] CY_RESET        = 16'd9938;

   typedef struct packed {
      logic [15:0] pixel_u;
      logic [15:0] pixel_v;
      logic [31:0] joint_x;
      logic [31:0] joint_y;
      logic [31:0] joint_z;
   } req_type;

   typedef struct packed {
      logic [31:0] ray_x;
      logic [31:0] ray_y;
      logic [31:0] ray_z;
      logic [31:0] proj_x;
      logic [31:0] proj_y;
      logic [31:0] proj_z;
   } rsp_type;

   typedef struct packed {
      logic [2:0][2:0][15:0] rot;
      logic [2:0][31:0]      trans;
      logic [31:0]           inv_focal;
      logic [15:0]           cx;
      logic [15:0]           cy;
   } cfg_type;

   typedef struct packed {
      logic [2:0][DIR_W-1:0] dir;
      logic [NUM_W-1:0]      num;
      logic [DEN_W-1:0]      den;
      logic [2:0][31:0]      ray;
   } mid_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       dz;
   } side_type;

   // Clamp a wide signed value to COORD_WIDTH bits and keep the low 32 bits.
   function automatic logic [31:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi_lim;
      logic signed [SUM_W-1:0] lo_lim;
      logic signed [SUM_W-1:0] r;
      hi_lim = $signed({{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
      lo_lim = $signed({{(SUM_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}});
      priority if (v > hi_lim) begin
         r = hi_lim;
      end else if (v < lo_lim) begin
         r = lo_lim;
      end else begin
         r = v;
      end
      return r[31:0];
   endfunction

endpackage

// ===== src/prpp_front.sv =====
// Front pipeline: back-projects the pixel and forms the two dot products.
module prpp_front import prpp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    push,
   output mid_type push_data,
   input  logic    full
);

   logic [FRONT_DEPTH-1:0] vf_ff, vf_in;
   logic en;

   logic signed [31:0] joint [3];
   logic signed [31:0] trans [3];

   logic signed [16:0] du_ff [2], du_in [2];
   logic signed [WDIFF_W-1:0] w1_ff [3], w1_in [3];
   logic signed [49:0] pu_ff [2], pu_in [2];
   logic signed [WDIFF_W-1:0] w2_ff [3];
   logic signed [29:0] a_ff [2], a_in [2];
   logic signed [WDIFF_W-1:0] w3_ff [3];
   logic signed [45:0] prod_ff [3][3], prod_in [3][3];
   logic signed [WDIFF_W-1:0] w4_ff [3];
   logic signed [DIR_W-1:0] d5_ff [3], d5_in [3];
   logic signed [WDIFF_W-1:0] w5_ff [3];
   logic signed [65:0] dw_ff [3], dw_in [3];
   logic signed [65:0] dd_ff [3], dd_in [3];
   logic signed [DIR_W-1:0] d6_ff [3];
   logic [31:0] ray6_ff [3], ray6_in [3];
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DIR_W-1:0] d7_ff [3];
   logic [31:0] ray7_ff [3];

   assign en        = !vf_ff[FRONT_DEPTH-1] || !full;
   assign req_stall = !en;
   assign push      = vf_ff[FRONT_DEPTH-1] && !full;
   assign vf_in     = {vf_ff[FRONT_DEPTH-2:0], req_valid};

   assign joint[0] = $signed(req_data.joint_x);
   assign joint[1] = $signed(req_data.joint_y);
   assign joint[2] = $signed(req_data.joint_z);

   always_comb begin
      logic signed [49:0] rnd;
      logic signed [47:0] acc;
      logic signed [15:0] coef;
      for (int i = 0; i < 3; i++) begin
         trans[i] = $signed(cfg.trans[i]);
         w1_in[i] = WDIFF_W'(joint[i]) - WDIFF_W'(trans[i]);
      end
      du_in[0] = $signed({1'b0, req_data.pixel_u}) - $signed({1'b0, cfg.cx});
      du_in[1] = $signed({1'b0, req_data.pixel_v}) - $signed({1'b0, cfg.cy});
      for (int k = 0; k < 2; k++) begin
         pu_in[k] = du_ff[k] * $signed({1'b0, cfg.inv_focal});
         rnd      = pu_ff[k] + 50'sd524288;
         a_in[k]  = rnd[49:20];
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 2; j++) begin
            prod_in[i][j] = $signed(cfg.rot[i][j]) * a_ff[j];
         end
         coef          = $signed(cfg.rot[i][2]);
         prod_in[i][2] = $signed({{14{coef[15]}}, coef, 16'd0});
         acc = 48'(prod_ff[i][0]) + 48'(prod_ff[i][1]) + 48'(prod_ff[i][2]) + 48'sd8192;
         d5_in[i]  = acc[46:14];
         dw_in[i]  = 66'(d5_ff[i]) * 66'(w5_ff[i]);
         dd_in[i]  = 66'(d5_ff[i]) * 66'(d5_ff[i]);
         ray6_in[i] = sat_coord(SUM_W'(d5_ff[i]) + SUM_W'(trans[i]));
      end
      num_in = {{2{dw_ff[0][65]}}, dw_ff[0][65:2]} + {{2{dw_ff[1][65]}}, dw_ff[1][65:2]}
             + {{2{dw_ff[2][65]}}, dw_ff[2][65:2]};
      den_in = dd_ff[0][65:2] + dd_ff[1][65:2] + dd_ff[2][65:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= '0;
      end else if (en) begin
         vf_ff <= vf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         du_ff   <= du_in;
         w1_ff   <= w1_in;
         pu_ff   <= pu_in;
         w2_ff   <= w1_ff;
         a_ff    <= a_in;
         w3_ff   <= w2_ff;
         prod_ff <= prod_in;
         w4_ff   <= w3_ff;
         d5_ff   <= d5_in;
         w5_ff   <= w4_ff;
         dw_ff   <= dw_in;
         dd_ff   <= dd_in;
         d6_ff   <= d5_ff;
         ray6_ff <= ray6_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
         for (int i = 0; i < 3; i++) begin
            d7_ff[i] <= d6_ff[i];
         end
         ray7_ff <= ray6_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         push_data.dir[i] = d7_ff[i];
         push_data.ray[i] = ray7_ff[i];
      end
      push_data.num = num_ff;
      push_data.den = den_ff;
   end

endmodule

// ===== src/prpp_queue.sv =====
// Short queue that decouples the front pipeline from the divider pipeline.
module prpp_queue import prpp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  mid_type push_data,
   output logic    full,
   input  logic    pop,
   output mid_type pop_data,
   output logic    empty
);

   mid_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/prpp_div_lane.sv =====
// One pipelined divider lane: rounded quotient of |d|*|num| by den, clamped to 2^50.
module prpp_div_lane import prpp_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [PROD_W-1:0] num_in,
   input  logic [DEN_W-1:0]  den_in,
   output logic [QUO_W-1:0]  quo_out
);

   typedef struct packed {
      logic             clamp;
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] nlo;
      logic [QUO_W-1:0] quo;
   } div_stage_type;

   div_stage_type st_ff [DIV_STEPS+1];
   div_stage_type st_in [DIV_STEPS+1];
   logic [QUO_W-1:0] quo_ff, quo_in;

   always_comb begin
      logic [LIM_W-1:0] lim;
      logic [DEN_W:0]   r2;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic             rnd;
      // The quotient exceeds 2^50 exactly when num >= (2^50 + 1) * den.
      lim = (LIM_W'(den_in) << 50) + LIM_W'(den_in);
      st_in[0].clamp = (LIM_W'(num_in) >= lim);
      st_in[0].den   = den_in;
      st_in[0].rem   = DEN_W'(num_in[PROD_W-1:QUO_W]);
      st_in[0].nlo   = num_in[QUO_W-1:0];
      st_in[0].quo   = '0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         r2   = {st_ff[k-1].rem, st_ff[k-1].nlo[QUO_W-1]};
         diff = r2 - {1'b0, st_ff[k-1].den};
         ge   = (r2 >= {1'b0, st_ff[k-1].den});
         st_in[k].clamp = st_ff[k-1].clamp;
         st_in[k].den   = st_ff[k-1].den;
         st_in[k].rem   = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
         st_in[k].nlo   = {st_ff[k-1].nlo[QUO_W-2:0], 1'b0};
         st_in[k].quo   = {st_ff[k-1].quo[QUO_W-2:0], ge};
      end
      // Round half away from zero on the magnitude.
      rnd = ({st_ff[DIV_STEPS].rem, 1'b0} >= {1'b0, st_ff[DIV_STEPS].den});
      quo_in = st_ff[DIV_STEPS].clamp ? QUO_CLAMP
                                      : st_ff[DIV_STEPS].quo + QUO_W'(rnd);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff  <= st_in;
         quo_ff <= quo_in;
      end
   end

   assign quo_out = quo_ff;

endmodule

// ===== src/prpp_back.sv =====
// Back pipeline: scales the direction by num/den and adds the camera position.
module prpp_back import prpp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    empty,
   input  mid_type pop_data,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [BACK_DEPTH-1:0] vb_ff, vb_in;
   logic en;

   side_type side_ff [SIDE_DEPTH];
   side_type side_in;

   logic [DIR_W-1:0]  ad_ff [3], ad_in [3];
   logic [MAG_W-1:0]  an_ff, an_in;
   logic [DEN_W-1:0]  den1_ff, den2_ff, den3_ff;
   logic [64:0]       pl_ff [3], pl_in [3];
   logic [64:0]       ph_ff [3], ph_in [3];
   logic [PROD_W-1:0] n_ff [3], n_in [3];
   logic [QUO_W-1:0]  quo [3];
   logic [31:0]       ray_ff [SIDE_DEPTH][3];
   logic [31:0]       proj_in [3];
   logic [31:0]       ray_out_ff [3];
   logic [31:0]       proj_ff [3];

   assign en        = !vb_ff[BACK_DEPTH-1] || !rsp_stall;
   assign pop       = en && !empty;
   assign vb_in     = {vb_ff[BACK_DEPTH-2:0], pop};
   assign rsp_valid = vb_ff[BACK_DEPTH-1];

   always_comb begin
      logic signed [NUM_W-1:0] num_s;
      logic [NUM_W-1:0]        num_abs;
      logic signed [SUM_W-1:0] t_ext;
      logic signed [SUM_W-1:0] q_ext;
      logic signed [SUM_W-1:0] p;
      num_s   = $signed(pop_data.num);
      num_abs = num_s[NUM_W-1] ? NUM_W'(-num_s) : pop_data.num;
      an_in   = num_abs[MAG_W-1:0];
      side_in.dz = (pop_data.den == '0);
      for (int i = 0; i < 3; i++) begin
         side_in.neg[i] = pop_data.dir[i][DIR_W-1] ^ num_s[NUM_W-1];
         ad_in[i] = pop_data.dir[i][DIR_W-1] ? DIR_W'(-$signed(pop_data.dir[i]))
                                             : pop_data.dir[i];
         pl_in[i] = 65'(ad_ff[i]) * 65'(an_ff[31:0]);
         ph_in[i] = 65'(ad_ff[i]) * 65'(an_ff[63:32]);
         n_in[i]  = PROD_W'(pl_ff[i]) + (PROD_W'(ph_ff[i]) << 32);
         t_ext = SUM_W'($signed(cfg.trans[i]));
         q_ext = $signed(SUM_W'(quo[i]));
         if (side_ff[SIDE_DEPTH-1].dz) begin
            p = t_ext;
         end else if (side_ff[SIDE_DEPTH-1].neg[i]) begin
            p = t_ext - q_ext;
         end else begin
            p = t_ext + q_ext;
         end
         proj_in[i] = sat_coord(p);
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      prpp_div_lane u_lane (
         .clock   (clock),
         .en      (en),
         .num_in  (n_ff[i]),
         .den_in  (den3_ff),
         .quo_out (quo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= '0;
      end else if (en) begin
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ad_ff   <= ad_in;
         an_ff   <= an_in;
         den1_ff <= pop_data.den;
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         den2_ff <= den1_ff;
         n_ff    <= n_in;
         den3_ff <= den2_ff;
         side_ff[0] <= side_in;
         for (int i = 0; i < 3; i++) begin
            ray_ff[0][i] <= pop_data.ray[i];
         end
         for (int s = 1; s < SIDE_DEPTH; s++) begin
            side_ff[s] <= side_ff[s-1];
            ray_ff[s]  <= ray_ff[s-1];
         end
         ray_out_ff <= ray_ff[SIDE_DEPTH-1];
         proj_ff    <= proj_in;
      end
   end

   always_comb begin
      rsp_data.ray_x  = ray_out_ff[0];
      rsp_data.ray_y  = ray_out_ff[1];
      rsp_data.ray_z  = ray_out_ff[2];
      rsp_data.proj_x = proj_ff[0];
      rsp_data.proj_y = proj_ff[1];
      rsp_data.proj_z = proj_ff[2];
   end

endmodule

// ===== src/pixel_ray_point_projection_top.sv =====
// Top level of the pixel ray point projection block: registers, front, queue and back.
//
// This block back-projects a pixel through a pinhole camera (equal focal lengths, principal
// point, rotation R, position t) into a world ray point d + t, and projects a 3-D joint point
// onto the line from t along d. It accepts one beat per clock cycle when not stalled and
// returns one result beat per input beat, in order. A beat passes the front pipeline (pixel
// offset, scaling by 1/f, rotation, dot products), a four-entry queue and the back pipeline,
// whose depth is set by the 51-step restoring divider used once per axis to form d*num/den.
// The front and back stall independently; the queue absorbs short stalls of the result side.
// The user must see that configuration is written through the csr_ port only while no beat
// is in flight; the block does not enforce this. A write takes effect once registered.
module pixel_ray_point_projection_top import prpp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic    push, full, pop, empty;
   mid_type push_data, pop_data;

   // Register file write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROT_ROW0:  cfg_in.rot[0]    = csr_wdata;
            CSR_ROT_ROW1:  cfg_in.rot[1]    = csr_wdata;
            CSR_ROT_ROW2:  cfg_in.rot[2]    = csr_wdata;
            CSR_TRANS_X:   cfg_in.trans[0]  = csr_wdata[31:0];
            CSR_TRANS_Y:   cfg_in.trans[1]  = csr_wdata[31:0];
            CSR_TRANS_Z:   cfg_in.trans[2]  = csr_wdata[31:0];
            CSR_INV_FOCAL: cfg_in.inv_focal = csr_wdata[31:0];
            CSR_PRINCIPAL: begin
               cfg_in.cx = csr_wdata[15:0];
               cfg_in.cy = csr_wdata[31:16];
            end
         endcase
      end
   end

   // Reset gives an identity rotation, a camera at the origin and a 25600-pixel focal length.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot[0]    <= ROT_ROW0_RESET;
         cfg_ff.rot[1]    <= ROT_ROW1_RESET;
         cfg_ff.rot[2]    <= ROT_ROW2_RESET;
         cfg_ff.trans     <= '0;
         cfg_ff.inv_focal <= INV_FOCAL_RESET;
         cfg_ff.cx        <= CX_RESET;
         cfg_ff.cy        <= CY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front computes the ray and both dot products for every accepted beat.
   prpp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   prpp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   // The back divides, rounds, clamps and adds the camera position; its last stage is the
   // output register.
   prpp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .empty     (empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/pixel_ray_point_projection_top_test.sv =====
// Self-checking testbench for the pixel ray point projection block.
`timescale 1ns / 1ps

module pixel_ray_point_projection_top_test;
   import prpp_pkg::*;

   // Clock, reset and the ports of the block under test.
   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pixel_ray_point_projection_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The bench keeps its own copy of the camera registers.
   logic [47:0] cam_rot [3];
   logic [31:0] cam_trans [3];
   logic [31:0] cam_inv_focal;
   logic [31:0] cam_principal;

   // Results still to arrive, oldest first, and the run's bookkeeping.
   rsp_type     pending_results [$];
   int          error_count;
   int          beats_sent;
   int          beats_checked;
   int          sender_idle_pct;
   int          receiver_idle_pct;

   // Ten-nanosecond clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Saturate a wide signed value to the coordinate width and keep the low 32 bits.
   function automatic logic [31:0] clamp_coord(input logic signed [127:0] v);
      logic signed [127:0] lim;
      lim = 128'sd1 <<< (COORD_WIDTH - 1);
      if (v > lim - 1) begin
         v = lim - 1;
      end else if (v < -lim) begin
         v = -lim;
      end
      return v[31:0];
   endfunction

   // Work out the ray point and the projected joint for one pixel and joint pair.
   function automatic rsp_type project_joint(input req_type r);
      logic signed [127:0] axis_a [3];
      logic signed [127:0] dir [3];
      logic signed [127:0] offset [3];
      logic signed [127:0] tpos [3];
      logic signed [127:0] acc;
      logic signed [127:0] num;
      logic signed [127:0] den;
      logic signed [127:0] du;
      logic signed [127:0] dv;
      logic [127:0]        mag;
      logic [127:0]        quo;
      logic [127:0]        rem;
      logic signed [127:0] coef;
      logic signed [127:0] pos;
      logic [31:0]         ray [3];
      logic [31:0]         prj [3];
      rsp_type             res;
      du = $signed({112'd0, r.pixel_u}) - $signed({112'd0, cam_principal[15:0]});
      dv = $signed({112'd0, r.pixel_v}) - $signed({112'd0, cam_principal[31:16]});
      axis_a[0] = (du * $signed({96'd0, cam_inv_focal}) + (128'sd1 <<< 19)) >>> 20;
      axis_a[1] = (dv * $signed({96'd0, cam_inv_focal}) + (128'sd1 <<< 19)) >>> 20;
      axis_a[2] = 128'sd65536;
      tpos[0] = $signed(cam_trans[0]);
      tpos[1] = $signed(cam_trans[1]);
      tpos[2] = $signed(cam_trans[2]);
      num = 0;
      den = 0;
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) begin
            coef = $signed(cam_rot[i][16*j +: 16]);
            acc  = acc + coef * axis_a[j];
         end
         dir[i] = (acc + (128'sd1 <<< 13)) >>> 14;
      end
      offset[0] = $signed(r.joint_x) - tpos[0];
      offset[1] = $signed(r.joint_y) - tpos[1];
      offset[2] = $signed(r.joint_z) - tpos[2];
      for (int i = 0; i < 3; i++) begin
         num = num + ((dir[i] * offset[i]) >>> 2);
         den = den + ((dir[i] * dir[i]) >>> 2);
      end
      for (int i = 0; i < 3; i++) begin
         ray[i] = clamp_coord(dir[i] + tpos[i]);
         pos = tpos[i];
         if (den > 0) begin
            // Magnitude division rounded half away from zero, clamped to 2^50.
            mag = (dir[i] < 0 ? -dir[i] : dir[i]) * (num < 0 ? -num : num);
            quo = mag / den;
            rem = mag % den;
            if (quo > (128'd1 << 50)) begin
               quo = 128'd1 << 50;
            end else if (2 * rem >= den) begin
               quo = quo + 1;
            end
            pos = ((dir[i] < 0) != (num < 0)) ? tpos[i] - $signed(quo) : tpos[i] + $signed(quo);
         end
         prj[i] = clamp_coord(pos);
      end
      res.ray_x  = ray[0];
      res.ray_y  = ray[1];
      res.ray_z  = ray[2];
      res.proj_x = prj[0];
      res.proj_y = prj[1];
      res.proj_z = prj[2];
      return res;
   endfunction

   // Write one camera register, both in the block and in the bench's copy.
   task automatic write_camera_reg(input csr_index_type idx, input logic [47:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_ROT_ROW0:  cam_rot[0] = value;
         CSR_ROT_ROW1:  cam_rot[1] = value;
         CSR_ROT_ROW2:  cam_rot[2] = value;
         CSR_TRANS_X:   cam_trans[0] = value[31:0];
         CSR_TRANS_Y:   cam_trans[1] = value[31:0];
         CSR_TRANS_Z:   cam_trans[2] = value[31:0];
         CSR_INV_FOCAL: cam_inv_focal = value[31:0];
         CSR_PRINCIPAL: cam_principal = value[31:0];
         default: ;
      endcase
   endtask

   // Present one beat at the falling edge and hold it until the block takes it.
   // Idle cycles come first, so valid never drops between back-to-back beats.
   task automatic send_beat(input req_type r, input rsp_type typed, input bit use_typed);
      rsp_type expected;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      expected = use_typed ? typed : project_joint(r);
      pending_results = {pending_results, expected};
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      beats_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected beat has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (5) @(negedge clock);
   endtask

   // Receiver: random stall driven at the falling edge, results sampled at the rising edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing expected: %h", $realtime, rsp_data);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            beats_checked++;
            if (rsp_data.ray_x !== want.ray_x) begin
               $display("%0t: ray_x expected %h got %h", $realtime, want.ray_x, rsp_data.ray_x);
               error_count++;
            end
            if (rsp_data.ray_y !== want.ray_y) begin
               $display("%0t: ray_y expected %h got %h", $realtime, want.ray_y, rsp_data.ray_y);
               error_count++;
            end
            if (rsp_data.ray_z !== want.ray_z) begin
               $display("%0t: ray_z expected %h got %h", $realtime, want.ray_z, rsp_data.ray_z);
               error_count++;
            end
            if (rsp_data.proj_x !== want.proj_x) begin
               $display("%0t: proj_x expected %h got %h", $realtime, want.proj_x,
                        rsp_data.proj_x);
               error_count++;
            end
            if (rsp_data.proj_y !== want.proj_y) begin
               $display("%0t: proj_y expected %h got %h", $realtime, want.proj_y,
                        rsp_data.proj_y);
               error_count++;
            end
            if (rsp_data.proj_z !== want.proj_z) begin
               $display("%0t: proj_z expected %h got %h", $realtime, want.proj_z,
                        rsp_data.proj_z);
               error_count++;
            end
         end
      end
   end

   // A random rotation row: mostly moderate coefficients, sometimes any 16-bit pattern.
   function automatic logic [47:0] random_rot_row();
      logic [47:0] row;
      for (int j = 0; j < 3; j++) begin
         if ($urandom_range(3) == 0) begin
            row[16*j +: 16] = $urandom();
         end else begin
            row[16*j +: 16] = 16'($signed($urandom_range(32768)) - 16384);
         end
      end
      return row;
   endfunction

   // A random joint coordinate: near the camera most of the time, full range otherwise.
   function automatic logic [31:0] random_coord();
      if ($urandom_range(3) == 0) begin
         return $urandom();
      end
      return 32'($signed($urandom_range(2000000)) - 1000000);
   endfunction

   // Directed table. Rows with a typed-in answer can be read straight off the math:
   // after reset the rotation is the identity and t is zero, so a pixel on the
   // principal point gives the ray (0, 0, 1) and a joint (x, y, z) projects to (0, 0, z).
   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type result;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 12;
   directed_row_type directed_rows [DIRECTED_ROWS];

   initial begin
      directed_rows[0]  = '{'{16'd12644, 16'd9938, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000},
                            1'b1, '{32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'h0003_0000}};
      directed_rows[1]  = '{'{16'd12644, 16'd9938, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000},
                            1'b1, '{32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'h8000_0000}};
      directed_rows[2]  = '{'{16'd12644, 16'd9938, 32'h0, 32'h0, 32'h7fff_ffff},
                            1'b1, '{32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'h7fff_ffff}};
      directed_rows[3]  = '{'{16'd0, 16'd0, 32'h0, 32'h0, 32'h0}, 1'b0, '0};
      directed_rows[4]  = '{'{16'hffff, 16'hffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
                            1'b0, '0};
      directed_rows[5]  = '{'{16'hffff, 16'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                            1'b0, '0};
      directed_rows[6]  = '{'{16'h0, 16'hffff, 32'hffff_ffff, 32'h0000_0001, 32'h0},
                            1'b0, '0};
      directed_rows[7]  = '{'{16'h5555, 16'haaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678},
                            1'b0, '0};
      directed_rows[8]  = '{'{16'haaaa, 16'h5555, 32'haaaa_aaaa, 32'h5555_5555, 32'hedcb_a988},
                            1'b0, '0};
      directed_rows[9]  = '{'{16'd12645, 16'd9937, 32'h0, 32'h0, 32'h0}, 1'b0, '0};
      directed_rows[10] = '{'{16'd13000, 16'd9000, 32'h0003_0000, 32'hfffe_0000, 32'h0005_0000},
                            1'b0, '0};
      directed_rows[11] = '{'{16'd100, 16'd30000, 32'hfff0_0000, 32'h0010_0000, 32'hffff_0000},
                            1'b0, '0};
   end

   // Run the directed table with whatever registers are loaded at the time.
   task automatic walk_directed_table(input bit allow_typed);
      for (int k = 0; k < DIRECTED_ROWS; k++) begin
         send_beat(directed_rows[k].beat, directed_rows[k].result,
                   allow_typed && directed_rows[k].typed);
      end
   endtask

   // One random phase: load a random camera, then stream random beats.
   task automatic random_phase(input int beats);
      req_type r;
      write_camera_reg(CSR_ROT_ROW0, random_rot_row());
      write_camera_reg(CSR_ROT_ROW1, random_rot_row());
      write_camera_reg(CSR_ROT_ROW2, random_rot_row());
      write_camera_reg(CSR_TRANS_X, {16'd0, random_coord()});
      write_camera_reg(CSR_TRANS_Y, {16'd0, random_coord()});
      write_camera_reg(CSR_TRANS_Z, {16'd0, random_coord()});
      case ($urandom_range(3))
         0:       write_camera_reg(CSR_INV_FOCAL, 48'd0);
         1:       write_camera_reg(CSR_INV_FOCAL, {16'd0, $urandom()});
         default: write_camera_reg(CSR_INV_FOCAL, 48'($urandom_range(20000000, 100000)));
      endcase
      write_camera_reg(CSR_PRINCIPAL, {16'd0, $urandom()});
      for (int k = 0; k < beats; k++) begin
         r.pixel_u = $urandom();
         r.pixel_v = $urandom();
         r.joint_x = random_coord();
         r.joint_y = random_coord();
         r.joint_z = random_coord();
         send_beat(r, '0, 1'b0);
      end
      drain_results();
   endtask

   // Main sequence.
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data          = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_ROT_ROW0;
      csr_wdata         = '0;
      error_count       = 0;
      beats_sent        = 0;
      beats_checked     = 0;
      sender_idle_pct   = 10;
      receiver_idle_pct = 52;
      cam_rot[0]        = ROT_ROW0_RESET;
      cam_rot[1]        = ROT_ROW1_RESET;
      cam_rot[2]        = ROT_ROW2_RESET;
      cam_trans[0]      = '0;
      cam_trans[1]      = '0;
      cam_trans[2]      = '0;
      cam_inv_focal     = INV_FOCAL_RESET;
      cam_principal     = {CY_RESET, CX_RESET};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset camera first, where the typed-in rows apply.
      walk_directed_table(1'b1);
      drain_results();

      // Extreme camera: every rotation coefficient at its most negative, t at the
      // rails, maximum 1/f and principal point at the far corner.
      write_camera_reg(CSR_ROT_ROW0, 48'h8000_8000_8000);
      write_camera_reg(CSR_ROT_ROW1, 48'h8000_8000_8000);
      write_camera_reg(CSR_ROT_ROW2, 48'h8000_8000_8000);
      write_camera_reg(CSR_TRANS_X, 48'h0000_7fff_ffff);
      write_camera_reg(CSR_TRANS_Y, 48'h0000_8000_0000);
      write_camera_reg(CSR_TRANS_Z, 48'h0000_7fff_ffff);
      write_camera_reg(CSR_INV_FOCAL, 48'h0000_ffff_ffff);
      write_camera_reg(CSR_PRINCIPAL, 48'h0000_ffff_ffff);
      walk_directed_table(1'b0);
      drain_results();

      // Positive rails of the rotation with zero 1/f: the ray runs along column 2.
      write_camera_reg(CSR_ROT_ROW0, 48'h7fff_7fff_7fff);
      write_camera_reg(CSR_ROT_ROW1, 48'h7fff_7fff_7fff);
      write_camera_reg(CSR_ROT_ROW2, 48'h7fff_7fff_7fff);
      write_camera_reg(CSR_INV_FOCAL, 48'd0);
      write_camera_reg(CSR_PRINCIPAL, 48'd0);
      walk_directed_table(1'b0);
      drain_results();

      // Degenerate direction: a zero rotation leaves the projection at t.
      write_camera_reg(CSR_ROT_ROW0, 48'd0);
      write_camera_reg(CSR_ROT_ROW1, 48'd0);
      write_camera_reg(CSR_ROT_ROW2, 48'd0);
      write_camera_reg(CSR_TRANS_X, 48'd0);
      write_camera_reg(CSR_TRANS_Y, 48'd0);
      write_camera_reg(CSR_TRANS_Z, 48'd0);
      walk_directed_table(1'b0);
      drain_results();

      // Random part in three idling regimes.
      for (int p = 0; p < 10; p++) begin
         random_phase(43);
      end
      sender_idle_pct   = 52;
      receiver_idle_pct = 10;
      for (int p = 0; p < 10; p++) begin
         random_phase(43);
      end
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      for (int p = 0; p < 10; p++) begin
         random_phase(43);
      end

      // Let the pipeline settle past its latency before the verdict.
      repeat (100) @(negedge clock);
      $display("Sent %0d beats and checked %0d results over reset, extreme, degenerate",
               beats_sent, beats_checked);
      $display("and thirty random camera settings under three idling regimes.");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog, far above the slowest correct run.
   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
